[hdl/size_class_block_allocator_defines.svh]
// Assertion macros for the size-class block allocator.
// Used by the top level only; no other dependencies.
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_DEFINES_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define SCBA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define SCBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/scba_pkg.sv]
`timescale 1ns / 1ps
// Package for the size-class block allocator: widths, codes, class table.
// No dependencies.
package scba_pkg;

  localparam int ChunkBytes    = 16384;
  localparam int MaxChunks     = 16;
  localparam int MaxBlockBytes = 640;
  localparam int SizeClasses   = 14;

  localparam int PoolUnits  = MaxChunks * (ChunkBytes / 16);
  localparam int UnitW      = $clog2(PoolUnits);
  localparam int LinkW      = 15;
  localparam int ClassW     = 4;
  localparam int ChunkW     = 5;
  localparam int ChunkUnits = ChunkBytes / 16;

  typedef logic [LinkW-1:0] link_t;
  typedef logic [UnitW-1:0] unit_t;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO      = 2'd1,
    ST_OVERSIZE  = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_LINK, S_CARVE, S_DONE
  } state_t;

  // class size in 16-byte units
  function automatic logic [6:0] class_units(input logic [ClassW-1:0] c);
    case (c)
      4'd0:  class_units = 7'd1;
      4'd1:  class_units = 7'd2;
      4'd2:  class_units = 7'd4;
      4'd3:  class_units = 7'd6;
      4'd4:  class_units = 7'd8;
      4'd5:  class_units = 7'd10;
      4'd6:  class_units = 7'd12;
      4'd7:  class_units = 7'd14;
      4'd8:  class_units = 7'd16;
      4'd9:  class_units = 7'd20;
      4'd10: class_units = 7'd24;
      4'd11: class_units = 7'd28;
      4'd12: class_units = 7'd32;
      4'd13: class_units = 7'd40;
      default: class_units = 7'd40;
    endcase
  endfunction

  // smallest class holding size; valid only for 1..640
  function automatic logic [ClassW-1:0] find_class(input logic [11:0] size);
    logic [ClassW-1:0] r;
    r = 4'd13;
    for (int i = SizeClasses - 1; i >= 0; i--) begin
      if (size <= {1'b0, class_units(ClassW'(i)), 4'b0000}) r = ClassW'(i);
    end
    find_class = r;
  endfunction

  typedef struct packed {
    logic              we;
    unit_t             waddr;
    link_t             wdata;
    unit_t             raddr;
  } link_req_t;

endpackage

[hdl/scba_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response transactions.
// Depends on scba_pkg.
interface scba_req_if import scba_pkg::*; (input logic clk);
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [11:0] size;
  logic [17:0] address;
  modport source (output valid, mode, size, address, input ready);
  modport sink (input valid, mode, size, address, output ready);
endinterface

interface scba_rsp_if import scba_pkg::*; (input logic clk);
  logic        valid;
  logic        ready;
  logic [17:0] address_res;
  logic [1:0]  status;
  modport source (output valid, address_res, status, input ready);
  modport sink (input valid, address_res, status, output ready);
endinterface

[hdl/scba_link_ram.sv]
`timescale 1ns / 1ps
// Next-link memory: one write port, one registered read port.
// Depends on scba_pkg.
module scba_link_ram import scba_pkg::*; (
  input  logic      clk,
  input  link_req_t req,
  output link_t     rdata
);
  link_t mem [PoolUnits];

  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= req.wdata;
    rdata <= mem[req.raddr];
  end
endmodule

[hdl/size_class_block_allocator.sv]
`timescale 1ns / 1ps
// Size-class block allocator: pop, push, clear and rejects pass through S_READ (link read),
// S_LINK (link arrival) and S_DONE (result load); a new request is taken only back in S_IDLE.
// A carve adds the S_CARVE state between S_LINK and S_DONE, one link write per cycle.
// A result waiting in the output register only holds back the load of the next one.
// Synchronous reset empties all class heads and the chunk count; links are left as is.
module size_class_block_allocator import scba_pkg::*; (
  input logic        clk,
  input logic        rst,
  scba_req_if.sink   req,
  scba_rsp_if.source rsp
);
`include "size_class_block_allocator_defines.svh"

  state_t state, state_next;
  link_t  heads [SizeClasses];
  logic   [SizeClasses-1:0] head_ok;
  logic   [ChunkW-1:0] chunks_used;

  logic   [1:0]        mode_r;
  logic   [ClassW-1:0] cls;
  unit_t               unit_r;
  logic   [UnitW:0]    carve_unit, carve_end;
  logic   [6:0]        bs;
  logic   [17:0]       res_addr;
  status_t             res_status;
  logic                rsp_valid;
  logic   [17:0]       rsp_addr;
  status_t             rsp_status;
  link_req_t           lreq;
  link_t               rdata;

  scba_link_ram u_ram (.clk(clk), .req(lreq), .rdata(rdata));

  wire accept  = req.valid && req.ready;
  wire link_t  head_c = head_ok[cls] ? heads[cls] : '0;
  wire [UnitW:0] carve_nx = carve_unit + {{(UnitW-6){1'b0}}, bs};
  // head moved away from the returned block: a fresh chunk was set up
  wire carve_go = (mode_r == MODE_ALLOC) && (res_status == ST_OK) && (head_c != '0) &&
                  (res_addr != (18'(head_c - 1'b1) << 4));
  wire rsp_load = (state == S_DONE) && (!rsp_valid || rsp.ready);

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.address_res = rsp_addr;
  assign rsp.status      = rsp_status;

  always_comb begin
    state_next = state;
    lreq = '0;
    lreq.raddr = unit_t'(head_c - 1'b1);
    case (state)
      S_IDLE:  if (accept) state_next = S_READ;
      S_READ:  state_next = S_LINK;
      S_LINK:  state_next = carve_go ? S_CARVE : S_DONE;
      S_CARVE: begin
        lreq.we    = 1'b1;
        lreq.waddr = carve_unit[UnitW-1:0];
        lreq.wdata = (carve_nx + bs > carve_end) ? '0 : link_t'(carve_nx + 1'b1);
        if (carve_nx + bs > carve_end) state_next = S_DONE;
      end
      S_DONE:  if (rsp_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    if (state == S_READ && mode_r == MODE_FREE && res_status == ST_OK) begin
      lreq.we    = 1'b1;
      lreq.waddr = unit_r;
      lreq.wdata = head_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head_ok     <= '0;
      chunks_used <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_load) rsp_valid <= 1'b1;
      else if (rsp_valid && rsp.ready) rsp_valid <= 1'b0;
      if (rsp_load) begin
        rsp_addr   <= res_addr;
        rsp_status <= res_status;
      end
      if (accept) begin
        mode_r     <= req.mode;
        cls        <= find_class(req.size);
        unit_r     <= unit_t'(req.address[17:4]);
        bs         <= class_units(find_class(req.size));
        res_addr   <= '0;
        res_status <= ST_OK;
        if (req.mode == MODE_CLEAR) begin
          head_ok     <= '0;
          chunks_used <= '0;
        end else if (req.mode != MODE_NONE) begin
          if (req.size == '0) res_status <= ST_ZERO;
          else if (req.size > 12'(MaxBlockBytes)) res_status <= ST_OVERSIZE;
        end
      end
      if (state == S_READ && res_status == ST_OK) begin
        if (mode_r == MODE_FREE) begin
          heads[cls]   <= link_t'({1'b0, unit_r} + 1'b1);
          head_ok[cls] <= 1'b1;
        end else if (mode_r == MODE_ALLOC && head_c == '0) begin
          if (chunks_used >= ChunkW'(MaxChunks)) res_status <= ST_EXHAUSTED;
          else begin
            res_addr    <= 18'(chunks_used) << $clog2(ChunkBytes);
            carve_unit  <= (UnitW+1)'(chunks_used) << $clog2(ChunkUnits);
            carve_end   <= ((UnitW+1)'(chunks_used) << $clog2(ChunkUnits)) +
                           (UnitW+1)'(ChunkUnits);
            chunks_used <= chunks_used + 1'b1;
            heads[cls]  <= ((UnitW+1)'(bs) >= (UnitW+1)'(ChunkUnits)) ? '0 :
                           link_t'(((UnitW+1)'(chunks_used) << $clog2(ChunkUnits)) + bs + 1'b1);
            head_ok[cls] <= 1'b1;
          end
        end else if (mode_r == MODE_ALLOC) begin
          res_addr <= 18'(head_c - 1'b1) << 4;
        end
      end
      // pop: the next link arrives in the cycle after the read
      if (state == S_LINK && mode_r == MODE_ALLOC && res_status == ST_OK) begin
        if (res_addr != '0 || head_c != '0) begin
          if (head_c != '0 && res_addr == (18'(head_c - 1'b1) << 4)) heads[cls] <= rdata;
        end
      end
      if (state == S_CARVE) carve_unit <= carve_nx;
    end
  end

  `SCBA_ASSERT_IMPL(a_ready_idle, req.ready, state == S_IDLE, "ready outside idle")
  `SCBA_ASSERT_NEXT(a_accept_busy, accept, state == S_READ, "accept did not start work")
  `SCBA_ASSERT_IMPL(a_chunks_bound, 1'b1, chunks_used <= ChunkW'(MaxChunks), "chunk count overflow")
endmodule
